// ----- rtl/ntfs_runlist_decoder_unit_macros.svh -----
// Assertion macros shared by the run list decoder modules.
`ifndef NTFS_RUNLIST_DECODER_UNIT_MACROS_SVH
`define NTFS_RUNLIST_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define NRD_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define NRD_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define NRD_ASSERT_IMP(lbl, ant, cons, msg)
`define NRD_ASSERT_NXT(lbl, ant, cons, msg)
`endif
`endif

// ----- rtl/nrd_pkg.sv -----
// Types and constants of the run list decoder.
package nrd_pkg;

    localparam int VCN_W  = 63;
    localparam int WORD_W = 64;
    localparam int CS_W   = 5;

    // Commands from the parser to the extent unit
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_EXTENT = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_EXTENT = 2'd0;
    localparam logic [1:0] ST_END    = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    // Register map (word index) and reset values
    localparam logic [0:0]      REG_CLUSTER_SHIFT   = 1'b0;
    localparam logic [CS_W-1:0] CLUSTER_SHIFT_RESET = 5'd12;

    typedef struct packed {
        logic [1:0]        op;
        logic [VCN_W-1:0]  start_vcn;
        logic [WORD_W-1:0] clusters;
        logic [WORD_W-1:0] len_bytes;
        logic [WORD_W-1:0] delta;
        logic              delta_zero;
        logic              eod;
    } nrd_cmd_t;

endpackage

// ----- rtl/nrd_stream_if.sv -----
// Valid/ready channels for input bytes and decoded results.
interface nrd_in_if;
    import nrd_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [7:0]       data_byte;
    logic [VCN_W-1:0] start_vcn;
    logic             end_of_data;

    modport source (output valid, kind, data_byte, start_vcn, end_of_data, input ready);
    modport sink   (input valid, kind, data_byte, start_vcn, end_of_data, output ready);
endinterface

interface nrd_out_if;
    import nrd_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [VCN_W-1:0] disk_offset;
    logic [VCN_W-1:0] length_bytes;
    logic [VCN_W-1:0] extent_vcn;
    logic             sparse;
    logic [VCN_W-1:0] total_bytes;
    logic             last;

    modport source (output valid, status, disk_offset, length_bytes, extent_vcn, sparse,
                    total_bytes, last, input ready);
    modport sink   (input valid, status, disk_offset, length_bytes, extent_vcn, sparse,
                    total_bytes, last, output ready);
endinterface

// ----- rtl/ntfs_runlist_decoder_unit.sv -----
// Top level of the NTFS mapping-pairs run list decoder.
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  ----------------------------------------------
//  in_ch     in   valid/ready             kind, data_byte, start_vcn, end_of_data
//  out_ch    out  valid/ready             status, disk_offset, length_bytes, extent_vcn,
//                                         sparse, total_bytes, last
//  apb       in   psel/penable/pready     cluster_shift at byte address 0
//
//  Throughput is one item per cycle while the command queue is not full. A result passes
//  from the item that completes its record through the command queue, then through the
//  extent unit into the output register.
//  Reset is asynchronous, active low; it sets cluster_shift to 12 and idles the parser.
//  The command queue (QUEUE_DEPTH entries) absorbs output stalls; in_ch.ready drops only
//  when it is full, and the output register holds a result until it is taken.
module ntfs_runlist_decoder_unit #(
    parameter int FIELD_BYTES_MAX = 8,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    nrd_in_if.sink      in_ch,
    nrd_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nrd_pkg::*;

    logic [CS_W-1:0] cluster_shift_reg, cluster_shift_next;
    logic            cfg_write;
    logic            cfg_hit;

    // Front to back: one command per start item or finished record
    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    nrd_cmd_t cmd_in;
    nrd_cmd_t cmd_out;

    // APB: zero-wait access; word index is paddr[2], the low byte bits are ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_hit   = (paddr[2] == REG_CLUSTER_SHIFT);
    assign prdata    = cfg_hit ? {27'd0, cluster_shift_reg} : 32'd0;

    always_comb
    begin
        cluster_shift_next = cluster_shift_reg;
        // Write only the shift; a write to any other word is dropped
        if (cfg_write && cfg_hit)
        begin
            cluster_shift_next = pwdata[CS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_shift_reg <= CLUSTER_SHIFT_RESET;
        end
        else
        begin
            cluster_shift_reg <= cluster_shift_next;
        end
    end

    // Parse bytes: header, length and offset fields; classify each record
    nrd_front #(
        .FIELD_BYTES_MAX (FIELD_BYTES_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .cluster_shift (cluster_shift_reg),
        .q_full        (q_full),
        .push          (push),
        .cmd           (cmd_in)
    );

    // Decouple parser and extent unit so each side stalls on its own
    nrd_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_in),
        .full    (q_full),
        .pop     (pop),
        .valid   (q_valid),
        .cmd_out (cmd_out)
    );

    // Advance running LCN, VCN and byte total; drive the result item
    nrd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cluster_shift (cluster_shift_reg),
        .q_valid       (q_valid),
        .cmd           (cmd_out),
        .pop           (pop),
        .out_ch        (out_ch)
    );

endmodule

// ----- rtl/nrd_front.sv -----
// Byte parser: walks headers and field bytes, issues one command per start item or finished record.
`include "ntfs_runlist_decoder_unit_macros.svh"
module nrd_front #(
    parameter int FIELD_BYTES_MAX = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    nrd_in_if.sink                  in_ch,
    input  logic [nrd_pkg::CS_W-1:0] cluster_shift,
    input  logic                    q_full,
    output logic                    push,
    output nrd_pkg::nrd_cmd_t       cmd
);
    import nrd_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_LEN    = 2'd2;
    localparam logic [1:0] PH_OFF    = 2'd3;
    localparam logic [3:0] MAX_CNT   = 4'(FIELD_BYTES_MAX);

    logic [1:0]        phase_reg, phase_next;
    logic [3:0]        len_cnt_reg, len_cnt_next;
    logic [3:0]        off_cnt_reg, off_cnt_next;
    logic [3:0]        idx_reg, idx_next;
    logic [WORD_W-1:0] clus_reg, clus_next;
    logic [WORD_W-1:0] delta_reg, delta_next;

    logic              fire;
    logic [7:0]        b;
    logic [3:0]        idx_inc;
    logic [WORD_W-1:0] byte_lane;
    logic [WORD_W-1:0] clus_acc;
    logic [WORD_W-1:0] delta_acc;
    logic [WORD_W-1:0] delta_ext;
    logic [2:0]        cnt_m1;
    logic              sign_bit;

    assign in_ch.ready = !q_full;
    assign fire        = in_ch.valid && in_ch.ready;
    assign b           = in_ch.data_byte;
    assign idx_inc     = idx_reg + 4'd1;
    assign byte_lane   = {56'd0, b} << {idx_reg[2:0], 3'b000};
    assign clus_acc    = clus_reg | byte_lane;
    assign delta_acc   = delta_reg | byte_lane;
    assign cnt_m1      = off_cnt_reg[2:0] - 3'd1;
    assign sign_bit    = delta_acc[{cnt_m1, 3'b111}];

    // Sign-fill every byte lane above the received offset bytes
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            delta_ext[8*k +: 8] = (4'(k) < off_cnt_reg) ? delta_acc[8*k +: 8] : {8{sign_bit}};
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        len_cnt_next = len_cnt_reg;
        off_cnt_next = off_cnt_reg;
        idx_next     = idx_reg;
        clus_next    = clus_reg;
        delta_next   = delta_reg;
        push         = 1'b0;
        cmd.op         = OP_START;
        cmd.start_vcn  = in_ch.start_vcn;
        cmd.clusters   = clus_reg;
        cmd.len_bytes  = clus_reg << cluster_shift;
        cmd.delta      = delta_ext;
        cmd.delta_zero = (delta_ext == '0);
        cmd.eod        = in_ch.end_of_data;

        if (fire)
        begin
            if (!in_ch.kind)
            begin
                // Start a new list: drop any partial record
                push         = 1'b1;
                cmd.op       = OP_START;
                phase_next   = PH_HEADER;
                len_cnt_next = '0;
                off_cnt_next = '0;
                idx_next     = '0;
                clus_next    = '0;
                delta_next   = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (b == 8'd0)
                        begin
                            push       = 1'b1;
                            cmd.op     = OP_END;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            len_cnt_next = b[3:0];
                            off_cnt_next = b[7:4];
                            if (b[3:0] > MAX_CNT || b[7:4] > MAX_CNT || in_ch.end_of_data)
                            begin
                                push       = 1'b1;
                                cmd.op     = OP_BAD;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                clus_next  = '0;
                                delta_next = '0;
                                phase_next = (b[3:0] != 4'd0) ? PH_LEN : PH_OFF;
                            end
                        end
                    end
                    PH_LEN:
                    begin
                        clus_next = clus_acc;
                        idx_next  = idx_inc;
                        if (idx_inc >= len_cnt_reg)
                        begin
                            if (off_cnt_reg == 4'd0)
                            begin
                                // Record without offset bytes: sparse extent
                                push           = 1'b1;
                                cmd.op         = OP_EXTENT;
                                cmd.clusters   = clus_acc;
                                cmd.len_bytes  = clus_acc << cluster_shift;
                                cmd.delta      = '0;
                                cmd.delta_zero = 1'b1;
                                phase_next     = in_ch.end_of_data ? PH_IDLE : PH_HEADER;
                            end
                            else if (in_ch.end_of_data)
                            begin
                                push       = 1'b1;
                                cmd.op     = OP_BAD;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                phase_next = PH_OFF;
                            end
                        end
                        else if (in_ch.end_of_data)
                        begin
                            push       = 1'b1;
                            cmd.op     = OP_BAD;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_OFF:
                    begin
                        delta_next = delta_acc;
                        idx_next   = idx_inc;
                        if (idx_inc >= off_cnt_reg)
                        begin
                            push       = 1'b1;
                            cmd.op     = OP_EXTENT;
                            phase_next = in_ch.end_of_data ? PH_IDLE : PH_HEADER;
                        end
                        else if (in_ch.end_of_data)
                        begin
                            push       = 1'b1;
                            cmd.op     = OP_BAD;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        // Idle: stream bytes are dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            len_cnt_reg <= '0;
            off_cnt_reg <= '0;
            idx_reg     <= '0;
            clus_reg    <= '0;
            delta_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            len_cnt_reg <= len_cnt_next;
            off_cnt_reg <= off_cnt_next;
            idx_reg     <= idx_next;
            clus_reg    <= clus_next;
            delta_reg   <= delta_next;
        end
    end

    `NRD_ASSERT_NXT(a_start_to_header, fire && !in_ch.kind, phase_reg == PH_HEADER, "start must enter header phase")
    `NRD_ASSERT_IMP(a_push_on_accept, push, fire, "command issued without an accepted item")
    `NRD_ASSERT_IMP(a_len_nonzero, phase_reg == PH_LEN, len_cnt_reg != 4'd0, "length phase with zero length bytes")

endmodule

// ----- rtl/nrd_cmd_queue.sv -----
// Short command queue between the parser and the extent unit.
`include "ntfs_runlist_decoder_unit_macros.svh"
module nrd_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nrd_pkg::nrd_cmd_t cmd_in,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output nrd_pkg::nrd_cmd_t cmd_out
);
    import nrd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    nrd_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `NRD_ASSERT_IMP(a_no_overflow, push, !full, "push into a full queue")
    `NRD_ASSERT_IMP(a_no_underflow, pop, valid, "pop from an empty queue")
    `NRD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ----- rtl/nrd_back.sv -----
// Extent unit: keeps running VCN, LCN and byte total, forms each result item.
`include "ntfs_runlist_decoder_unit_macros.svh"
module nrd_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [nrd_pkg::CS_W-1:0] cluster_shift,
    input  logic                     q_valid,
    input  nrd_pkg::nrd_cmd_t        cmd,
    output logic                     pop,
    nrd_out_if.source                out_ch
);
    import nrd_pkg::*;

    logic [WORD_W-1:0] vcn_reg, vcn_next;
    logic [WORD_W-1:0] lcn_reg, lcn_next;
    logic [WORD_W-1:0] total_reg, total_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        st_reg, st_next;
    logic [VCN_W-1:0]  off_reg, off_next;
    logic [VCN_W-1:0]  len_reg, len_next;
    logic [VCN_W-1:0]  evcn_reg, evcn_next;
    logic              sp_reg, sp_next;
    logic [VCN_W-1:0]  tot_reg, tot_next;
    logic              last_reg, last_next;

    logic [WORD_W-1:0] new_lcn;
    logic [WORD_W-1:0] new_total;
    logic [WORD_W-1:0] off_full;
    logic              is_sparse;

    assign pop       = q_valid && (!out_valid_reg || out_ch.ready);
    assign new_lcn   = lcn_reg + cmd.delta;
    assign new_total = total_reg + cmd.len_bytes;
    assign is_sparse = cmd.delta_zero || (new_lcn == '0);
    assign off_full  = new_lcn << cluster_shift;

    always_comb
    begin
        vcn_next       = vcn_reg;
        lcn_next       = lcn_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        st_next        = st_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        evcn_next      = evcn_reg;
        sp_next        = sp_reg;
        tot_next       = tot_reg;
        last_next      = last_reg;
        if (pop)
        begin
            case (cmd.op)
                OP_START:
                begin
                    vcn_next   = {1'b0, cmd.start_vcn};
                    lcn_next   = '0;
                    total_next = '0;
                end
                OP_EXTENT:
                begin
                    lcn_next       = new_lcn;
                    total_next     = new_total;
                    vcn_next       = vcn_reg + cmd.clusters;
                    out_valid_next = 1'b1;
                    st_next        = ST_EXTENT;
                    off_next       = is_sparse ? '0 : off_full[VCN_W-1:0];
                    len_next       = cmd.len_bytes[VCN_W-1:0];
                    evcn_next      = vcn_reg[VCN_W-1:0];
                    sp_next        = is_sparse;
                    tot_next       = new_total[VCN_W-1:0];
                    last_next      = cmd.eod;
                end
                default:
                begin
                    // End marker or bad record: report position and total, close the list
                    out_valid_next = 1'b1;
                    st_next        = (cmd.op == OP_END) ? ST_END : ST_BAD;
                    off_next       = '0;
                    len_next       = '0;
                    evcn_next      = vcn_reg[VCN_W-1:0];
                    sp_next        = 1'b0;
                    tot_next       = total_reg[VCN_W-1:0];
                    last_next      = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcn_reg       <= '0;
            lcn_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vcn_reg       <= vcn_next;
            lcn_reg       <= lcn_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        off_reg  <= off_next;
        len_reg  <= len_next;
        evcn_reg <= evcn_next;
        sp_reg   <= sp_next;
        tot_reg  <= tot_next;
        last_reg <= last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = st_reg;
    assign out_ch.disk_offset  = off_reg;
    assign out_ch.length_bytes = len_reg;
    assign out_ch.extent_vcn   = evcn_reg;
    assign out_ch.sparse       = sp_reg;
    assign out_ch.total_bytes  = tot_reg;
    assign out_ch.last         = last_reg;

    `NRD_ASSERT_IMP(a_status_legal, out_valid_reg, st_reg != ST_UNUSED, "unused status code")
    `NRD_ASSERT_IMP(a_sparse_zero_off, out_valid_reg && sp_reg, off_reg == '0, "sparse extent with a disk offset")
    `NRD_ASSERT_IMP(a_stop_is_last, out_valid_reg && st_reg != ST_EXTENT, last_reg && !sp_reg && len_reg == '0, "end or error result not closing the list")

endmodule
